### hw/rtl/spadd_pkg.sv
`default_nettype none

package spadd_pkg;

  // field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned COEFF_W = 16;
  localparam int unsigned EXP_W   = 10;
  localparam int unsigned SUM_W   = COEFF_W + 1;

  // default list capacity
  localparam int unsigned MAX_TERMS_DEF = 16;

  // item modes
  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MERGE  = 2'd2;

  // one stored term
  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff;
    logic [EXP_W-1:0]          exponent;
  } term_t;

  // decision of the compare/add unit
  typedef struct packed {
    logic take_a;
    logic take_b;
  } pick_t;

endpackage

`default_nettype wire

### hw/rtl/spadd_if.sv
`default_nettype none

// input item channel
interface spadd_in_if;
  import spadd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [COEFF_W-1:0] coeff;
  logic [EXP_W-1:0]          exponent;

  modport source (output valid, output mode, output coeff, output exponent, input ready);
  modport sink (input valid, input mode, input coeff, input exponent, output ready);
endinterface

// result item channel
interface spadd_out_if;
  import spadd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum_coeff;
  logic [EXP_W-1:0]        sum_exponent;
  logic                    last;
  logic                    empty_res;
  logic                    overflowed;

  modport source (
    output valid, output sum_coeff, output sum_exponent, output last,
    output empty_res, output overflowed, input ready
  );
  modport sink (
    input valid, input sum_coeff, input sum_exponent, input last,
    input empty_res, input overflowed, output ready
  );
endinterface

`default_nettype wire

### hw/rtl/spadd_list_mem.sv
`default_nettype none

module spadd_list_mem #(
  parameter int unsigned DEPTH = spadd_pkg::MAX_TERMS_DEF,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [IDX_W-1:0]  waddr_i,
  input  wire spadd_pkg::term_t  wdata_i,
  input  wire logic [IDX_W-1:0]  raddr_i,
  output spadd_pkg::term_t       rdata_o
);
  import spadd_pkg::*;

  term_t mem_q [DEPTH];
  term_t rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/spadd_term_alu.sv
`default_nettype none

module spadd_term_alu (
  input  wire spadd_pkg::term_t                  a_i,
  input  wire spadd_pkg::term_t                  b_i,
  input  wire logic                              a_avail_i,
  input  wire logic                              b_avail_i,
  output spadd_pkg::pick_t                       pick_o,
  output logic signed [spadd_pkg::SUM_W-1:0]     sum_coeff_o,
  output logic [spadd_pkg::EXP_W-1:0]            sum_exponent_o
);
  import spadd_pkg::*;

  logic signed [SUM_W-1:0] a_ext;
  logic signed [SUM_W-1:0] b_ext;

  assign a_ext = {a_i.coeff[COEFF_W-1], a_i.coeff};
  assign b_ext = {b_i.coeff[COEFF_W-1], b_i.coeff};

  // exponent compare picks the head term, equal heads are added
  always_comb begin
    pick_o = '0;
    if (a_avail_i && b_avail_i) begin
      if (a_i.exponent > b_i.exponent) begin
        pick_o.take_a = 1'b1;
      end else if (a_i.exponent < b_i.exponent) begin
        pick_o.take_b = 1'b1;
      end else begin
        pick_o.take_a = 1'b1;
        pick_o.take_b = 1'b1;
      end
    end else begin
      pick_o.take_a = a_avail_i;
      pick_o.take_b = b_avail_i && !a_avail_i;
    end

    if (pick_o.take_a && pick_o.take_b) begin
      sum_coeff_o = a_ext + b_ext;
    end else if (pick_o.take_a) begin
      sum_coeff_o = a_ext;
    end else begin
      sum_coeff_o = b_ext;
    end
    sum_exponent_o = pick_o.take_a ? a_i.exponent : b_i.exponent;
  end

endmodule

`default_nettype wire

### hw/rtl/sparse_polynomial_add_merge_core.sv
// sequence: a load is written into its list when accepted; a merge item enters ST_MERGE,
// then its terms are registered in the output register one per cycle while it is taken
// throughput: one load per cycle, one merged term per cycle from the shared compare/add unit
// the block is not ready from a merge until its last term is taken
// reset: asynchronous, active low; clears both counts, the dropped flag and the sequencer,
// list memories are not cleared and need no clearing pass
`default_nettype none

module sparse_polynomial_add_merge_core #(
  parameter int unsigned MAX_TERMS = spadd_pkg::MAX_TERMS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  spadd_in_if.sink          in_i,
  spadd_out_if.source       out_o
);
  import spadd_pkg::*;

  localparam int unsigned IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_DRAIN
  } state_e;

  state_e                  state_q;
  logic [CNT_W-1:0]        cnt_a_q;
  logic [CNT_W-1:0]        cnt_b_q;
  logic [CNT_W-1:0]        i_q, i_d;
  logic [CNT_W-1:0]        j_q, j_d;
  logic                    dropped_q;
  logic                    out_valid_q;
  logic signed [SUM_W-1:0] out_coeff_q;
  logic [EXP_W-1:0]        out_exp_q;
  logic                    out_last_q;
  logic                    out_empty_q;
  logic                    out_ovf_q;

  logic                    in_fire;
  logic                    we_a;
  logic                    we_b;
  logic                    mrg_fire;
  logic                    out_fire;
  logic                    last_d;
  logic [IDX_W-1:0]        raddr_a;
  logic [IDX_W-1:0]        raddr_b;
  term_t                   wterm;
  term_t                   head_a;
  term_t                   head_b;
  pick_t                   pick;
  logic signed [SUM_W-1:0] alu_coeff;
  logic [EXP_W-1:0]        alu_exp;

  assign wterm.coeff    = in_i.coeff;
  assign wterm.exponent = in_i.exponent;

  // handshake and pointer advance
  always_comb begin
    in_fire  = (state_q == ST_IDLE) && in_i.valid;
    we_a     = in_fire && (in_i.mode == MODE_LOAD_A) && (cnt_a_q < CNT_MAX);
    we_b     = in_fire && (in_i.mode == MODE_LOAD_B) && (cnt_b_q < CNT_MAX);
    out_fire = out_valid_q && out_o.ready;
    mrg_fire = (state_q == ST_MERGE) && (!out_valid_q || out_o.ready);
    i_d = i_q;
    j_d = j_q;
    if (mrg_fire) begin
      if (pick.take_a) begin
        i_d = i_q + CNT_ONE;
      end
      if (pick.take_b) begin
        j_d = j_q + CNT_ONE;
      end
    end
    if ((state_q == ST_DRAIN) && out_fire) begin
      i_d = '0;
      j_d = '0;
    end
    last_d  = (i_d >= cnt_a_q) && (j_d >= cnt_b_q);
    raddr_a = (i_d < CNT_MAX) ? i_d[IDX_W-1:0] : '0;
    raddr_b = (j_d < CNT_MAX) ? j_d[IDX_W-1:0] : '0;
  end

  // term lists
  spadd_list_mem #(
    .DEPTH (MAX_TERMS),
    .IDX_W (IDX_W)
  ) u_list_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[IDX_W-1:0]),
    .wdata_i (wterm),
    .raddr_i (raddr_a),
    .rdata_o (head_a)
  );

  spadd_list_mem #(
    .DEPTH (MAX_TERMS),
    .IDX_W (IDX_W)
  ) u_list_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[IDX_W-1:0]),
    .wdata_i (wterm),
    .raddr_i (raddr_b),
    .rdata_o (head_b)
  );

  // shared compare/add unit
  spadd_term_alu u_alu (
    .a_i            (head_a),
    .b_i            (head_b),
    .a_avail_i      (i_q < cnt_a_q),
    .b_avail_i      (j_q < cnt_b_q),
    .pick_o         (pick),
    .sum_coeff_o    (alu_coeff),
    .sum_exponent_o (alu_exp)
  );

  // sequencer, counts and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_coeff_q <= '0;
      out_exp_q   <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      i_q <= i_d;
      j_q <= j_d;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_i.mode)
              MODE_LOAD_A: begin
                if (we_a) begin
                  cnt_a_q <= cnt_a_q + CNT_ONE;
                end else begin
                  dropped_q <= 1'b1;
                end
              end
              MODE_LOAD_B: begin
                if (we_b) begin
                  cnt_b_q <= cnt_b_q + CNT_ONE;
                end else begin
                  dropped_q <= 1'b1;
                end
              end
              MODE_MERGE: begin
                if ((cnt_a_q == '0) && (cnt_b_q == '0)) begin
                  // empty sum: one flagged result
                  out_valid_q <= 1'b1;
                  out_coeff_q <= '0;
                  out_exp_q   <= '0;
                  out_last_q  <= 1'b1;
                  out_empty_q <= 1'b1;
                  out_ovf_q   <= dropped_q;
                  state_q     <= ST_DRAIN;
                end else begin
                  state_q <= ST_MERGE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MERGE: begin
          if (mrg_fire) begin
            out_valid_q <= 1'b1;
            out_coeff_q <= alu_coeff;
            out_exp_q   <= alu_exp;
            out_last_q  <= last_d;
            out_empty_q <= 1'b0;
            out_ovf_q   <= dropped_q;
            if (last_d) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_fire) begin
            out_valid_q <= 1'b0;
            cnt_a_q     <= '0;
            cnt_b_q     <= '0;
            dropped_q   <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.sum_coeff    = out_coeff_q;
  assign out_o.sum_exponent = out_exp_q;
  assign out_o.last         = out_last_q;
  assign out_o.empty_res    = out_empty_q;
  assign out_o.overflowed   = out_ovf_q;

endmodule

`default_nettype wire

### hw/rtl/spadd_checker.sv
`default_nettype none

module spadd_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_ready_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic signed [spadd_pkg::SUM_W-1:0] sum_coeff_i,
  input wire logic [spadd_pkg::EXP_W-1:0]        sum_exponent_i,
  input wire logic                              last_i,
  input wire logic                              empty_res_i
);
  import spadd_pkg::*;

  // a waiting result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item withdrawn before taken");

  // no new item is taken while a result is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while a result is pending");

  // an empty sum is a single zero term
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && empty_res_i |-> last_i && (sum_coeff_i == '0) && (sum_exponent_i == '0))
    else $error("malformed empty result");

  // after the last term is taken the block takes items again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && last_i |=> in_ready_i && !out_valid_i)
    else $error("block not ready after last result");

endmodule

bind sparse_polynomial_add_merge_core spadd_checker u_spadd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .sum_coeff_i    (out_o.sum_coeff),
  .sum_exponent_i (out_o.sum_exponent),
  .last_i         (out_o.last),
  .empty_res_i    (out_o.empty_res)
);

`default_nettype wire
